FILE: rtl/core/sge_pkg.sv
// Shared types and constants for the Scharr gradient energy block.
// No dependencies; imported by sge_energy and scharr_gradient_energy.
package sge_pkg;

  // Field widths of the result channel.
  localparam int unsigned ENERGY_W = 15;
  localparam int unsigned COL_W    = 11;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned IDX_W    = 2;

  // Largest frame height the row counter supports.
  localparam logic [CFG_W-1:0] MAX_HEIGHT = 13'd4096;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [11:0]      WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // One RGB pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // The eight neighbors a Scharr kernel looks at (the center has weight zero).
  typedef struct packed {
    pixel_t tl;
    pixel_t tm;
    pixel_t tr;
    pixel_t ml;
    pixel_t mr;
    pixel_t bl;
    pixel_t bm;
    pixel_t br;
  } sge_taps_t;

endpackage

FILE: rtl/core/sge_energy.sv
// Combinational Scharr L1 energy of one 3x3 neighborhood over three channels.
// Depends on sge_pkg for the pixel and tap types.
module sge_energy import sge_pkg::*; (
  input  sge_taps_t           taps,
  output logic [ENERGY_W-1:0] energy
);

  // |dx| + |dy| for one channel; each response stays within +/-4080.
  function automatic logic [12:0] chan_energy(
    input logic [7:0] tl, input logic [7:0] tm, input logic [7:0] tr,
    input logic [7:0] ml, input logic [7:0] mr,
    input logic [7:0] bl, input logic [7:0] bm, input logic [7:0] br
  );
    logic signed [13:0] dx;
    logic signed [13:0] dy;
    logic [13:0]        ax;
    logic [13:0]        ay;
    logic [13:0]        s;
    dx = 14'sd3  * ($signed({6'b0, tr}) - $signed({6'b0, tl}))
       + 14'sd10 * ($signed({6'b0, mr}) - $signed({6'b0, ml}))
       + 14'sd3  * ($signed({6'b0, br}) - $signed({6'b0, bl}));
    dy = 14'sd3  * ($signed({6'b0, bl}) - $signed({6'b0, tl}))
       + 14'sd10 * ($signed({6'b0, bm}) - $signed({6'b0, tm}))
       + 14'sd3  * ($signed({6'b0, br}) - $signed({6'b0, tr}));
    ax = dx[13] ? 14'(-dx) : 14'(dx);
    ay = dy[13] ? 14'(-dy) : 14'(dy);
    s  = ax + ay;
    return s[12:0];
  endfunction

  logic [12:0] e_red;
  logic [12:0] e_green;
  logic [12:0] e_blue;

  // Per-channel responses.
  assign e_red   = chan_energy(taps.tl.red, taps.tm.red, taps.tr.red, taps.ml.red,
                               taps.mr.red, taps.bl.red, taps.bm.red, taps.br.red);
  assign e_green = chan_energy(taps.tl.green, taps.tm.green, taps.tr.green,
                               taps.ml.green, taps.mr.green, taps.bl.green,
                               taps.bm.green, taps.br.green);
  assign e_blue  = chan_energy(taps.tl.blue, taps.tm.blue, taps.tr.blue,
                               taps.ml.blue, taps.mr.blue, taps.bl.blue,
                               taps.bm.blue, taps.br.blue);

  // Sum over channels; the maximum of 24480 fits the result width.
  assign energy = {2'b0, e_red} + {2'b0, e_green} + {2'b0, e_blue};

endmodule

FILE: rtl/core/scharr_gradient_energy.sv
// Top level of the streaming Scharr gradient energy block.
// Depends on sge_pkg and instantiates sge_energy.
//
// RGB pixels enter in raster order and each produces up to four energy results:
// the pixel one row up and one column left, the last pixel of that row at the
// row end, and in the frame's last row the same two for the current row. A
// pixel is held in an input stage while its two older rows are read from a
// single line memory (one read and one write port), then moves into the 3x3
// window, where one shared energy unit feeds the output register with one
// result per cycle while the output is not stalled. An item stays in the window
// stage until each result it causes has been loaded: a row's last pixel causes
// up to two results, a pixel of the frame's last row up to two, and the frame's
// final pixel up to four. The sustained rate is one pixel per cycle in the body
// of the frame while the output accepts results, less in its last row. Pixels
// pass through the input stage, the window stage and the output register. A
// write to the width or height register restarts the frame at row 0, column 0.
module scharr_gradient_energy import sge_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  // Pixel input channel.
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  // Energy result channel.
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ENERGY_W-1:0] out_energy,
  output logic [COL_W-1:0]    out_col,
  output logic [ROW_W-1:0]    out_row,
  output logic                out_run_last,
  output logic                out_frame_last,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

  // ---------------------------------------------------------------------------
  // Configuration and effective frame size
  // ---------------------------------------------------------------------------
  logic [11:0]      image_width_r;
  logic [CFG_W-1:0] image_height_r;
  logic [13:0]      w_ext;
  logic [13:0]      w_m1_wide;
  logic [CW-1:0]    w_m1;
  logic [ROW_W-1:0] h_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width_r <= cfg_data[11:0];
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height_r <= cfg_data;
      end
    end
  end

  // Zero acts as one; oversize values clamp to the supported maximum.
  assign w_ext     = {2'b0, image_width_r};
  assign w_m1_wide = (w_ext == 14'd0) ? 14'd0 :
                     (w_ext > MAXW)   ? MAXW - 14'd1 : w_ext - 14'd1;
  assign w_m1      = w_m1_wide[CW-1:0];

  always_comb begin
    if (image_height_r == '0) begin
      h_m1 = '0;
    end else if (image_height_r > MAX_HEIGHT) begin
      h_m1 = '1;
    end else begin
      h_m1 = ROW_W'(image_height_r - 13'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position of the next pixel
  // ---------------------------------------------------------------------------
  logic             in_xfer;
  logic             cfg_hit;
  logic [CW-1:0]    col_count_r;
  logic [CW-1:0]    col_count_nxt;
  logic [ROW_W-1:0] row_count_r;
  logic [ROW_W-1:0] row_count_nxt;

  assign in_xfer = in_valid && in_ready;
  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (cfg_hit) begin
      col_count_nxt = '0;
      row_count_nxt = '0;
    end else if (in_xfer) begin
      if (col_count_r == w_m1) begin
        col_count_nxt = '0;
        row_count_nxt = (row_count_r == h_m1) ? '0 : row_count_r + 1'b1;
      end else begin
        col_count_nxt = col_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage and line memory
  // Each entry holds {two rows up, one row up} for its column.
  // ---------------------------------------------------------------------------
  logic             s1_valid_r;
  pixel_t           s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_adv;
  logic [47:0]      line_mem [MAX_WIDTH];
  logic [47:0]      rd_r;
  logic             byp_r;
  logic [47:0]      byp_data_r;
  logic [47:0]      s1_lines;
  logic [47:0]      wr_data;

  // A write-back to the column being read in the same cycle is forwarded.
  assign s1_lines = byp_r ? byp_data_r : rd_r;
  assign wr_data  = {s1_lines[23:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_col_r] <= wr_data;
    end
    if (in_xfer) begin
      rd_r <= line_mem[col_count_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
        byp_r      <= s1_adv && (s1_col_r == col_count_r);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_r   <= '{red: in_red, green: in_green, blue: in_blue};
      s1_col_r   <= col_count_r;
      s1_row_r   <= row_count_r;
      byp_data_r <= wr_data;
    end
  end

  assign in_ready = !s1_valid_r || s1_adv;

  // ---------------------------------------------------------------------------
  // Window stage: the 3x3 neighborhood plus the list of results still owed
  // Pending bits: 0 row above left, 1 row above at row end,
  //               2 last row left,  3 last row at row end.
  // ---------------------------------------------------------------------------
  pixel_t           win_r [3][3];
  logic [3:0]       pend_r;
  logic [3:0]       pend_new;
  logic [3:0]       pend_sel;
  logic [3:0]       pend_rest;
  logic [CW-1:0]    s2_col_r;
  logic [ROW_W-1:0] s2_row_r;
  logic             out_load;
  logic             s2_free;

  // Lowest pending result goes first.
  assign pend_sel  = pend_r & (~pend_r + 4'd1);
  assign pend_rest = pend_r & ~pend_sel;
  assign out_load  = (pend_r != 4'd0) && (!out_valid || out_ready);
  assign s2_free   = (pend_r == 4'd0) || (out_load && pend_rest == 4'd0);
  assign s1_adv    = s1_valid_r && s2_free;

  always_comb begin
    pend_new[0] = (s1_row_r != '0) && (s1_col_r != '0);
    pend_new[1] = (s1_row_r != '0) && (s1_col_r == w_m1);
    pend_new[2] = (s1_row_r == h_m1) && (s1_col_r != '0);
    pend_new[3] = (s1_row_r == h_m1) && (s1_col_r == w_m1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      pend_r <= pend_new;
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= s1_lines[47:24];
      win_r[1][2] <= s1_lines[23:0];
      win_r[2][2] <= s1_pix_r;
    end else if (out_load) begin
      pend_r <= pend_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_col_r <= s1_col_r;
      s2_row_r <= s1_row_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Border clamping: pick window rows and columns for the selected result
  // ---------------------------------------------------------------------------
  logic             sel_end;
  logic             sel_last_row;
  logic [1:0]       t_idx;
  logic [1:0]       m_idx;
  logic [1:0]       l_idx;
  logic [1:0]       k_idx;
  logic [CW-1:0]    sel_x;
  logic [ROW_W-1:0] sel_y;
  sge_taps_t        taps;
  logic [ENERGY_W-1:0] energy;

  function automatic pixel_t pick(input pixel_t w [3][3], input logic [1:0] r,
                                  input logic [1:0] c);
    logic [1:0] rr;
    logic [1:0] cc;
    rr = (r == 2'd3) ? 2'd2 : r;
    cc = (c == 2'd3) ? 2'd2 : c;
    return w[rr][cc];
  endfunction

  assign sel_end      = pend_sel[1] || pend_sel[3];
  assign sel_last_row = pend_sel[2] || pend_sel[3];

  always_comb begin
    if (sel_last_row) begin
      t_idx = (s2_row_r == '0) ? 2'd2 : 2'd1;
      m_idx = 2'd2;
      sel_y = s2_row_r;
    end else begin
      t_idx = (s2_row_r == ROW_W'(1)) ? 2'd1 : 2'd0;
      m_idx = 2'd1;
      sel_y = s2_row_r - 1'b1;
    end
    if (sel_end) begin
      l_idx = (s2_col_r == '0) ? 2'd2 : 2'd1;
      k_idx = 2'd2;
      sel_x = s2_col_r;
    end else begin
      l_idx = (s2_col_r == CW'(1)) ? 2'd1 : 2'd0;
      k_idx = 2'd1;
      sel_x = s2_col_r - 1'b1;
    end
  end

  always_comb begin
    taps.tl = pick(win_r, t_idx, l_idx);
    taps.tm = pick(win_r, t_idx, k_idx);
    taps.tr = pick(win_r, t_idx, 2'd2);
    taps.ml = pick(win_r, m_idx, l_idx);
    taps.mr = pick(win_r, m_idx, 2'd2);
    taps.bl = pick(win_r, 2'd2, l_idx);
    taps.bm = pick(win_r, 2'd2, k_idx);
    taps.br = pick(win_r, 2'd2, 2'd2);
  end

  sge_energy u_energy (
    .taps   (taps),
    .energy (energy)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [CW+COL_W-1:0] sel_x_ext;
  logic                out_valid_r;

  assign sel_x_ext = {{COL_W{1'b0}}, sel_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Only the row-end result of the last row can be the frame's final pixel.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_energy     <= energy;
      out_col        <= sel_x_ext[COL_W-1:0];
      out_row        <= sel_y;
      out_run_last   <= (pend_rest == 4'd0);
      out_frame_last <= pend_sel[3];
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_last |-> out_run_last)
    else $error("frame end result is not the last of its run");

  a_more_results_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_run_last |-> pend_r != 4'd0)
    else $error("result marked not last but nothing is pending");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    col_count_r <= w_m1)
    else $error("column counter beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    row_count_r <= h_m1)
    else $error("row counter beyond frame height");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the scharr_gradient_energy streaming block.
// Depends on sge_pkg and the RTL top level; it predicts every energy result
// internally and checks each output transfer against it.
`timescale 1ns / 1ps

module testbench;
  import sge_pkg::*;

  localparam int LINE_DEPTH    = 2048;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int RANDOM_PIXELS = 50;

  // One expected energy result.
  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic                run_last;
    logic                frame_last;
  } energy_rec_t;

  // One pending stimulus entry: a pixel or a register write.
  typedef struct packed {
    logic             is_reg_write;
    logic             wait_drain;
    pixel_t           px;
    logic [IDX_W-1:0] reg_index;
    logic [CFG_W-1:0] data;
  } feed_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_red = 8'd0;
  logic [7:0]          in_green = 8'd0;
  logic [7:0]          in_blue = 8'd0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  logic [ENERGY_W-1:0] out_energy;
  logic [COL_W-1:0]    out_col;
  logic [ROW_W-1:0]    out_row;
  logic                out_run_last;
  logic                out_frame_last;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  feed_item_t  feed_q[$];
  energy_rec_t energy_q[$];

  int pix_sent = 0;
  int pix_taken = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_hold = 0;
  int mismatches = 0;
  int cycle_count = 0;

  // Predictor state: the two line stores, the 3x3 window and the frame position.
  pixel_t      line_old [LINE_DEPTH];
  pixel_t      line_new [LINE_DEPTH];
  pixel_t      win [3][3];
  int unsigned col_pos;
  int unsigned row_pos;
  logic [11:0] width_reg;
  logic [12:0] height_reg;

  scharr_gradient_energy #(.MAX_WIDTH(LINE_DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_energy     (out_energy),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic int channel_of(input pixel_t p, input int ch);
    case (ch)
      0: return int'(p.red);
      1: return int'(p.green);
      default: return int'(p.blue);
    endcase
  endfunction

  // Sum of |dx| + |dy| over the channels, window rows t/m/b and columns l/k/2.
  function automatic logic [ENERGY_W-1:0] window_energy(input int t, input int m,
                                                        input int b, input int l,
                                                        input int k);
    int ch, tl, tm, tr, ml, mr, bl, bm, br, dx, dy, sum;
    sum = 0;
    for (ch = 0; ch < 3; ch++) begin
      tl = channel_of(win[t][l], ch);
      tm = channel_of(win[t][k], ch);
      tr = channel_of(win[t][2], ch);
      ml = channel_of(win[m][l], ch);
      mr = channel_of(win[m][2], ch);
      bl = channel_of(win[b][l], ch);
      bm = channel_of(win[b][k], ch);
      br = channel_of(win[b][2], ch);
      dx = 3 * (tr - tl) + 10 * (mr - ml) + 3 * (br - bl);
      dy = 3 * (bl - tl) + 10 * (bm - tm) + 3 * (br - tr);
      sum += ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
    end
    return sum[ENERGY_W-1:0];
  endfunction

  // Advance the window by one pixel and queue the energies it completes.
  task automatic predict_energy(input pixel_t px);
    int unsigned w, h, c, r, y;
    int          pass, t, m, b, n, i;
    energy_rec_t rec;
    energy_rec_t batch [4];
    w = (width_reg == 12'd0) ? 1 :
        ((int'(width_reg) > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg));
    h = (height_reg == 13'd0) ? 1 :
        ((height_reg > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(height_reg));
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_old[c];
    win[1][2] = line_new[c];
    win[2][2] = px;
    line_old[c] = line_new[c];
    line_new[c] = px;

    // First the row above is finished; in the last row, the row itself too.
    n = 0;
    for (pass = 0; pass < 2; pass++) begin
      if ((pass == 0 && r != 0) || (pass == 1 && r == h - 1)) begin
        if (pass == 0) begin
          y = r - 1;
          t = (y == 0) ? 1 : 0;
          m = 1;
          b = 2;
        end else begin
          y = r;
          t = (r == 0) ? 2 : 1;
          m = 2;
          b = 2;
        end
        // The left neighbor column is never the row's last, so it never ends a frame.
        if (c >= 1) begin
          rec.energy = window_energy(t, m, b, (c == 1) ? 1 : 0, 1);
          rec.col = COL_W'(c - 1);
          rec.row = ROW_W'(y);
          rec.run_last = 1'b0;
          rec.frame_last = 1'b0;
          batch[n] = rec;
          n++;
        end
        // At the row end the current column is finished with its right edge clamped.
        if (c == w - 1) begin
          rec.energy = window_energy(t, m, b, (c == 0) ? 2 : 1, 2);
          rec.col = COL_W'(c);
          rec.row = ROW_W'(y);
          rec.run_last = 1'b0;
          rec.frame_last = (y == h - 1);
          batch[n] = rec;
          n++;
        end
      end
    end
    if (n > 0) begin
      rec = batch[n-1];
      rec.run_last = 1'b1;
      batch[n-1] = rec;
    end
    for (i = 0; i < n; i++) energy_q.push_back(batch[i]);

    col_pos = c + 1;
    row_pos = r;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got, input energy_rec_t exp_rec);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 20) begin
        $display("%0t ns: %s mismatch for pixel (%0d,%0d): expected %0d, got %0d",
                 $time, what, exp_rec.col, exp_rec.row, want, got);
      end
    end
  endtask

  // Monitor: checks each output transfer, then tracks register writes and
  // input transfers in the predictor.
  always @(posedge clk) begin : monitor
    energy_rec_t want;
    int          i;
    if (!rst_n) begin
      for (i = 0; i < LINE_DEPTH; i++) begin
        line_old[i] = '0;
        line_new[i] = '0;
      end
      for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
      col_pos = 0;
      row_pos = 0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (energy_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 20) begin
            $display("%0t ns: result with nothing expected: energy %0d at (%0d,%0d)",
                     $time, out_energy, out_col, out_row);
          end
        end else begin
          want = energy_q.pop_front();
          check_field("energy", 32'(want.energy), 32'(out_energy), want);
          check_field("out_col", 32'(want.col), 32'(out_col), want);
          check_field("out_row", 32'(want.row), 32'(out_row), want);
          check_field("run_last", 32'(want.run_last), 32'(out_run_last), want);
          check_field("frame_last", 32'(want.frame_last), 32'(out_frame_last), want);
        end
      end
      // Any write to a defined register restarts the frame.
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_reg = cfg_data[11:0];
          col_pos = 0;
          row_pos = 0;
        end else if (cfg_index == REG_IMAGE_HEIGHT) begin
          height_reg = cfg_data;
          col_pos = 0;
          row_pos = 0;
        end
      end
      if (in_valid && in_ready) begin
        pix_taken = pix_taken + 1;
        predict_energy({in_red, in_green, in_blue});
      end
    end
  end

  // Driver: presents pixels in bursts with gaps and issues register writes
  // only once the block has gone quiet.
  always @(negedge clk) begin : sender
    feed_item_t nxt;
    logic       launch;
    if (rst_n) begin
      launch = 1'b0;
      if (in_valid || pix_sent != pix_taken || energy_q.size() != 0) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end

      if (cfg_we) begin
        cfg_we <= 1'b0;
      end else if (pix_sent == pix_taken && feed_q.size() != 0) begin
        nxt = feed_q[0];
        if (nxt.is_reg_write) begin
          if (quiet_cycles >= SETTLE_CYCLES) begin
            nxt = feed_q.pop_front();
            cfg_we <= 1'b1;
            cfg_index <= nxt.reg_index;
            cfg_data <= nxt.data;
          end
        end else if (burst_left == 0) begin
          if (gap_left > 0) begin
            gap_left <= gap_left - 1;
          end else begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 16);
            gap_left <= $urandom_range(0, 8);
          end
        end else if (!nxt.wait_drain || energy_q.size() == 0) begin
          nxt = feed_q.pop_front();
          launch = 1'b1;
          burst_left <= burst_left - 1;
          in_red <= nxt.px.red;
          in_green <= nxt.px.green;
          in_blue <= nxt.px.blue;
          pix_sent <= pix_sent + 1;
        end
      end
      // Valid holds while a transfer is outstanding.
      if (pix_sent == pix_taken) in_valid <= launch;
    end
  end

  // Receiver: ready runs of random length broken by short stalls.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= !out_ready;
      if (out_ready) begin
        ready_hold <= $urandom_range(0, 4);
      end else begin
        ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
    end
  end

  task automatic queue_pixel(input pixel_t px, input logic drain);
    feed_item_t item;
    item = '0;
    item.px = px;
    item.wait_drain = drain;
    feed_q.push_back(item);
  endtask

  task automatic queue_reg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    feed_item_t item;
    item = '0;
    item.is_reg_write = 1'b1;
    item.reg_index = idx;
    item.data = value;
    feed_q.push_back(item);
  endtask

  task automatic queue_random_pixels(input int count);
    int i;
    for (i = 0; i < count; i++) queue_pixel(24'($urandom), 1'b0);
  endtask

  initial begin : stimulus
    int           x, y, i, n, sel, wv, hv, ew, eh, rand_pix;
    logic         first_phase;
    logic [CFG_W-1:0] wdata;
    pixel_t       px;

    // Reset sizes of 640 x 480: the first few pixels of row 0.
    queue_random_pixels(4);

    // Zero width and zero height act as one, so every pixel is a whole frame.
    queue_reg_write(REG_IMAGE_WIDTH, 13'h1000);
    queue_reg_write(REG_IMAGE_HEIGHT, 13'd0);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b0);

    // Single column of three rows.
    queue_reg_write(REG_IMAGE_WIDTH, 13'd1);
    queue_reg_write(REG_IMAGE_HEIGHT, 13'd3);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hFF00FF, 1'b0);

    // Single row of three; bit 12 of the width write is dropped.
    queue_reg_write(REG_IMAGE_WIDTH, 13'h1003);
    queue_reg_write(REG_IMAGE_HEIGHT, 13'd1);
    queue_pixel(24'h000000, 1'b0);
    queue_pixel(24'hFFFFFF, 1'b0);
    queue_pixel(24'h00FF00, 1'b0);

    // 3 x 3 frame with a hard edge of a different direction in each channel.
    queue_reg_write(REG_IMAGE_HEIGHT, 13'd3);
    for (y = 0; y < 3; y++) begin
      for (x = 0; x < 3; x++) begin
        px.red = (x > y) ? 8'hFF : 8'h00;
        px.green = (x + y >= 2) ? 8'hFF : 8'h00;
        px.blue = (y >= 1) ? 8'hFF : 8'h00;
        queue_pixel(px, 1'b0);
      end
    end

    // 2 x 2 frame running into the next one; the sender holds off once
    // until every outstanding result has arrived.
    queue_reg_write(REG_IMAGE_WIDTH, 13'd2);
    queue_reg_write(REG_IMAGE_HEIGHT, 13'd2);
    for (i = 0; i < 6; i++) queue_pixel(24'($urandom), i == 4);

    // Random frame sizes: mostly whole frames, some cut off, some noise writes.
    rand_pix = 0;
    first_phase = 1'b1;
    while (rand_pix < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 9);
      wv = $urandom_range(1, 6);
      hv = $urandom_range(1, 5);
      if (sel == 0) begin
        wv = 0;
      end else if (sel == 1) begin
        hv = 0;
      end else if (sel == 2) begin
        wv = $urandom_range(LINE_DEPTH + 1, 4095);
        hv = 1;
      end
      wdata = CFG_W'(wv);
      wdata[12] = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1) != 0) begin
        queue_reg_write(REG_IMAGE_WIDTH, wdata);
        queue_reg_write(REG_IMAGE_HEIGHT, CFG_W'(hv));
      end else begin
        queue_reg_write(REG_IMAGE_HEIGHT, CFG_W'(hv));
        queue_reg_write(REG_IMAGE_WIDTH, wdata);
      end
      // A write to an unused index must leave the frame position alone.
      if (sel == 3) queue_reg_write(IDX_W'($urandom_range(2, 3)), CFG_W'($urandom));
      ew = (wv == 0) ? 1 : ((wv > LINE_DEPTH) ? LINE_DEPTH : wv);
      eh = (hv == 0) ? 1 : hv;
      if (sel == 2) begin
        n = $urandom_range(2, 8);
      end else if (sel >= 7) begin
        n = $urandom_range(1, ew * eh);
      end else begin
        n = ew * eh * $urandom_range(1, 2);
      end
      for (i = 0; i < n; i++) begin
        queue_pixel(24'($urandom),
                    (i == n / 2) && (first_phase || $urandom_range(0, 2) == 0));
      end
      rand_pix += n;
      first_phase = 1'b0;
    end

    // Widest row: 4095 acts as the line store depth, in a single-row frame.
    queue_reg_write(REG_IMAGE_WIDTH, 13'h0FFF);
    queue_reg_write(REG_IMAGE_HEIGHT, 13'd1);
    queue_random_pixels(6);

    // Tallest frame: 8191 acts as 4096 rows of one pixel.
    queue_reg_write(REG_IMAGE_WIDTH, 13'd1);
    queue_reg_write(REG_IMAGE_HEIGHT, 13'h1FFF);
    queue_random_pixels(6);

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (!(feed_q.size() == 0 && pix_sent == pix_taken && energy_q.size() == 0 && !cfg_we)
           && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
    end

    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, energy_q.size());
      $display("testbench: FAIL");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (mismatches == 0 && energy_q.size() == 0) begin
        $display("testbench: PASS");
      end else begin
        $display("testbench: FAIL");
      end
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sge_pkg.sv
rtl/core/sge_energy.sv
rtl/core/scharr_gradient_energy.sv
verif/testbench.sv
